/* design/rsi_pkg.sv */
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and constants of the running Simpson integrator
// Widths, reset value of the step register, phase codes and stage control.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int SUM_WIDTH_DEF    = 48;

  localparam int DT_W   = 16;
  localparam int INT_W  = 64;
  localparam int DIV_W  = 64;
  localparam int PROD_W = DT_W + DIV_W;

  localparam logic [DT_W-1:0] DT_RESET = 16'd6554;

  // floor(v / 3) = (v * RECIP3) >> RECIP3_SHIFT for v < 2^19
  localparam int         RECIP3_SHIFT = 19;
  localparam logic [17:0] RECIP3      = 18'd174763;

  typedef enum logic [1:0] {
    PH_OPEN0,
    PH_OPEN1,
    PH_OPEN2
  } phase_e;

  typedef struct packed {
    logic valid;
    logic sum_sat;
  } rsi_ctl_t;

  // width of the weighted sum plus tail, enough to add without wrap
  function automatic int acc_width(int sw, int suw);
    return ((suw > sw + 8) ? suw : sw + 8) + 1;
  endfunction

endpackage

`default_nettype wire

/* design/rsi_acc.sv */
// ----------------------------------------------------------------------------
// rsi_acc: panel accumulator
// Tracks the open panel, folds completed 3/8 panels into the saturating
// weighted sum and registers the weighted total including the open tail.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_acc #(
  parameter int SAMPLE_WIDTH = rsi_pkg::SAMPLE_WIDTH_DEF,
  parameter int SUM_WIDTH    = rsi_pkg::SUM_WIDTH_DEF
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  adv_i,
  input  logic                                                  in_valid_i,
  input  logic signed [SAMPLE_WIDTH-1:0]                        sample_i,
  output logic signed [rsi_pkg::acc_width(SAMPLE_WIDTH, SUM_WIDTH)-1:0] w_o,
  output rsi_pkg::rsi_ctl_t                                     ctl_o
);

  import rsi_pkg::*;

  localparam int ACC_W = acc_width(SAMPLE_WIDTH, SUM_WIDTH);
  localparam int EXT_W = SAMPLE_WIDTH + 8;

  localparam logic signed [ACC_W-1:0] SUM_HI = ACC_W'({1'b0, {(SUM_WIDTH-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SUM_LO = ~SUM_HI;

  logic                           acc;
  logic                           have_first_q, have_first_d;
  phase_e                         phase_q, phase_d;
  logic signed [SAMPLE_WIDTH-1:0] held0_q, held0_d;
  logic signed [SAMPLE_WIDTH-1:0] held1_q, held1_d;
  logic signed [SAMPLE_WIDTH-1:0] end_q, end_d;
  logic signed [SUM_WIDTH-1:0]    wsum_q, wsum_d;
  logic                           sum_sat_q, sum_sat_d;
  logic signed [ACC_W-1:0]        w_q, w_d;
  rsi_ctl_t                       ctl_q;

  logic signed [EXT_W-1:0] s_x, e_x, a_x, b_x;
  logic signed [EXT_W-1:0] sum0, sum1, sum2;
  logic signed [EXT_W-1:0] tail0, tail1, panel;
  logic signed [ACC_W-1:0] t_sum, t_clamp;
  logic                    t_ovf;

  assign acc = in_valid_i && adv_i;

  always_comb begin
    s_x   = EXT_W'(sample_i);
    e_x   = EXT_W'(end_q);
    a_x   = EXT_W'(held0_q);
    b_x   = EXT_W'(held1_q);
    sum0  = e_x + s_x;
    sum1  = e_x + (a_x <<< 2) + s_x;
    sum2  = e_x + (a_x <<< 1) + a_x + (b_x <<< 1) + b_x + s_x;
    tail0 = (sum0 <<< 3) + (sum0 <<< 2);
    tail1 = sum1 <<< 3;
    panel = (sum2 <<< 3) + sum2;
    t_sum = ACC_W'(wsum_q) + ACC_W'(panel);
    t_ovf = 1'b0;
    if (t_sum > SUM_HI) begin
      t_clamp = SUM_HI;
      t_ovf   = 1'b1;
    end else if (t_sum < SUM_LO) begin
      t_clamp = SUM_LO;
      t_ovf   = 1'b1;
    end else begin
      t_clamp = t_sum;
    end
  end

  always_comb begin
    have_first_d = have_first_q;
    phase_d      = phase_q;
    held0_d      = held0_q;
    held1_d      = held1_q;
    end_d        = end_q;
    wsum_d       = wsum_q;
    sum_sat_d    = sum_sat_q;
    w_d          = '0;
    if (!have_first_q) begin
      end_d        = sample_i;
      have_first_d = 1'b1;
      phase_d      = PH_OPEN0;
    end else begin
      unique case (phase_q)
        PH_OPEN0: begin
          held0_d = sample_i;
          phase_d = PH_OPEN1;
          w_d     = ACC_W'(wsum_q) + ACC_W'(tail0);
        end
        PH_OPEN1: begin
          held1_d = sample_i;
          phase_d = PH_OPEN2;
          w_d     = ACC_W'(wsum_q) + ACC_W'(tail1);
        end
        PH_OPEN2: begin
          wsum_d    = SUM_WIDTH'(t_clamp);
          sum_sat_d = sum_sat_q | t_ovf;
          end_d     = sample_i;
          phase_d   = PH_OPEN0;
          w_d       = t_clamp;
        end
        default: begin
          phase_d = PH_OPEN0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_first_q <= 1'b0;
      phase_q      <= PH_OPEN0;
      held0_q      <= '0;
      held1_q      <= '0;
      end_q        <= '0;
      wsum_q       <= '0;
      sum_sat_q    <= 1'b0;
    end else if (acc) begin
      have_first_q <= have_first_d;
      phase_q      <= phase_d;
      held0_q      <= held0_d;
      held1_q      <= held1_d;
      end_q        <= end_d;
      wsum_q       <= wsum_d;
      sum_sat_q    <= sum_sat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q.valid   <= in_valid_i;
      ctl_q.sum_sat <= sum_sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      w_q <= w_d;
    end
  end

  assign w_o   = w_q;
  assign ctl_o = ctl_q;

`ifndef SYNTHESIS
  a_fresh_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_first_q |-> (wsum_q == '0) && !sum_sat_q && (phase_q == PH_OPEN0))
    else $error("accumulator state moved before the first sample");
`endif

endmodule

`default_nettype wire

/* design/rsi_scale.sv */
// ----------------------------------------------------------------------------
// rsi_scale: result scaling pipeline
// Splits |W| into W/24 and W%24, multiplies by the step, clamps to 64 bits
// and holds the result word in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_scale #(
  parameter int SAMPLE_WIDTH = rsi_pkg::SAMPLE_WIDTH_DEF,
  parameter int SUM_WIDTH    = rsi_pkg::SUM_WIDTH_DEF
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  adv_i,
  input  logic [rsi_pkg::DT_W-1:0]                              dt_i,
  input  logic signed [rsi_pkg::acc_width(SAMPLE_WIDTH, SUM_WIDTH)-1:0] w_i,
  input  rsi_pkg::rsi_ctl_t                                     ctl_i,
  output logic                                                  out_valid_o,
  output logic signed [rsi_pkg::INT_W-1:0]                      integral_o,
  output logic                                                  saturated_o
);

  import rsi_pkg::*;

  localparam int ACC_W = acc_width(SAMPLE_WIDTH, SUM_WIDTH);
  localparam int HALF  = DIV_W / 2;
  localparam int PP_W  = DT_W + HALF;
  localparam int DR_W  = DT_W + 5;
  localparam int V_W   = DR_W - 3;
  localparam int FP_W  = V_W + 18;

  localparam logic [PROD_W-1:0] LIM_POS = PROD_W'({1'b0, {(INT_W-1){1'b1}}});
  localparam logic [PROD_W-1:0] LIM_NEG = LIM_POS + 1'b1;

  rsi_ctl_t ctl2_q, ctl3_q, ctl4_q, ctl5_q, ctl6_q, ctl7_q, ctl8_q;
  logic     neg2_q, neg3_q, neg4_q, neg5_q, neg6_q, neg7_q, neg8_q;
  logic [2:0]       lo2_q, lo3_q, lo4_q, lo5_q;
  logic [DIV_W-1:0] u2_q, u3_q, u4_q;
  logic [DIV_W-1:0] q2_q, q3_q, q4_q, q5_q, qf6_q;
  logic [7:0]       r5_q;
  logic [4:0]       r24_6_q;
  logic [PP_W-1:0]  plo7_q, phi7_q, plo8_q, phi8_q;
  logic [V_W-1:0]   v7_q;
  logic [DT_W-1:0]  f8_q;
  logic             out_valid_q, res_sat_q, sat_q;
  logic [INT_W-1:0] int_q;

  logic             neg2_d;
  logic [ACC_W-1:0] mag;
  logic [DIV_W-1:0] u2_d, q2_d, t3, q3_d, t4, q4_d, r5_full, qf6_d;
  logic [11:0]      r11;
  logic [6:0]       corr;
  logic [7:0]       rem8;
  logic [PP_W-1:0]  plo7_d, phi7_d;
  logic [DR_W-1:0]  dr;
  logic [FP_W-1:0]  fp;
  logic [PROD_W-1:0] total, lim, m;
  logic             ovf;
  logic [INT_W-1:0] m64, res;

  always_comb begin
    neg2_d  = w_i[ACC_W-1];
    mag     = neg2_d ? (~w_i + 1'b1) : w_i;
    u2_d    = DIV_W'(mag >> 3);
    q2_d    = (u2_d >> 2) + (u2_d >> 4);
    t3      = q2_q + (q2_q >> 4);
    q3_d    = t3 + (t3 >> 8);
    t4      = q3_q + (q3_q >> 16);
    q4_d    = t4 + (t4 >> HALF);
    r5_full = u4_q - (q4_q + (q4_q << 1));
    r11     = ({4'b0, r5_q} << 3) + ({4'b0, r5_q} << 1) + {4'b0, r5_q};
    corr    = r11[11:5];
    qf6_d   = q5_q + DIV_W'(corr);
    rem8    = r5_q - 8'(({1'b0, corr} << 1) + {1'b0, corr});
    plo7_d  = PP_W'(dt_i) * PP_W'(qf6_q[HALF-1:0]);
    phi7_d  = PP_W'(dt_i) * PP_W'(qf6_q[DIV_W-1:HALF]);
    dr      = DR_W'(dt_i) * DR_W'(r24_6_q);
    fp      = FP_W'(v7_q) * FP_W'(RECIP3);
    total   = (PROD_W'(phi8_q) << HALF) + PROD_W'(plo8_q) + PROD_W'(f8_q);
    lim     = neg8_q ? LIM_NEG : LIM_POS;
    ovf     = total > lim;
    m       = ovf ? lim : total;
    m64     = m[INT_W-1:0];
    res     = neg8_q ? (~m64 + 1'b1) : m64;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q      <= '0;
      ctl3_q      <= '0;
      ctl4_q      <= '0;
      ctl5_q      <= '0;
      ctl6_q      <= '0;
      ctl7_q      <= '0;
      ctl8_q      <= '0;
      out_valid_q <= 1'b0;
      res_sat_q   <= 1'b0;
    end else if (adv_i) begin
      ctl2_q      <= ctl_i;
      ctl3_q      <= ctl2_q;
      ctl4_q      <= ctl3_q;
      ctl5_q      <= ctl4_q;
      ctl6_q      <= ctl5_q;
      ctl7_q      <= ctl6_q;
      ctl8_q      <= ctl7_q;
      out_valid_q <= ctl8_q.valid;
      if (ctl8_q.valid) begin
        res_sat_q <= res_sat_q | ovf;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      neg2_q  <= neg2_d;
      lo2_q   <= mag[2:0];
      u2_q    <= u2_d;
      q2_q    <= q2_d;
      neg3_q  <= neg2_q;
      lo3_q   <= lo2_q;
      u3_q    <= u2_q;
      q3_q    <= q3_d;
      neg4_q  <= neg3_q;
      lo4_q   <= lo3_q;
      u4_q    <= u3_q;
      q4_q    <= q4_d;
      neg5_q  <= neg4_q;
      lo5_q   <= lo4_q;
      r5_q    <= r5_full[7:0];
      q5_q    <= q4_q;
      neg6_q  <= neg5_q;
      qf6_q   <= qf6_d;
      r24_6_q <= {rem8[1:0], lo5_q};
      neg7_q  <= neg6_q;
      plo7_q  <= plo7_d;
      phi7_q  <= phi7_d;
      v7_q    <= dr[DR_W-1:3];
      neg8_q  <= neg7_q;
      plo8_q  <= plo7_q;
      phi8_q  <= phi7_q;
      f8_q    <= fp[RECIP3_SHIFT +: DT_W];
      if (ctl8_q.valid) begin
        int_q <= res;
        sat_q <= res_sat_q | ctl8_q.sum_sat | ovf;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign integral_o  = int_q;
  assign saturated_o = sat_q;

`ifndef SYNTHESIS
  a_sticky_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && ctl8_q.valid && res_sat_q |=> saturated_o)
    else $error("earlier result clamp not reflected in saturated flag");
`endif

endmodule

`default_nettype wire

/* design/running_simpson_integrator.sv */
// ----------------------------------------------------------------------------
// running_simpson_integrator: running integral by the composite 3/8 rule
// Top level: step register, flow control, accumulator and scaling pipeline.
// ----------------------------------------------------------------------------
// One sample is accepted every cycle while in_stall_o is low. Each result
// word passes the panel accumulator register, then seven stages that divide
// the weighted total by 24 with a reciprocal series and multiply by the step
// in 16x32 partial products, then the output register. A stalled result word
// freezes the whole pipeline, so in_stall_o follows out_stall_i while a word is
// held. The user writes dt_step only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module running_simpson_integrator #(
  parameter int SAMPLE_WIDTH = rsi_pkg::SAMPLE_WIDTH_DEF,
  parameter int SUM_WIDTH    = rsi_pkg::SUM_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             dt_step_we_i,
  input  logic [rsi_pkg::DT_W-1:0]         dt_step_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [rsi_pkg::INT_W-1:0] integral_o,
  output logic                             saturated_o
);

  import rsi_pkg::*;

  localparam int ACC_W = acc_width(SAMPLE_WIDTH, SUM_WIDTH);

  logic [DT_W-1:0]         dt_q;
  logic                    adv;
  logic signed [ACC_W-1:0] w;
  rsi_ctl_t                ctl;

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= DT_RESET;
    end else if (dt_step_we_i) begin
      dt_q <= dt_step_i;
    end
  end

  rsi_acc #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .sample_i   (sample_i),
    .w_o        (w),
    .ctl_o      (ctl)
  );

  rsi_scale #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .dt_i        (dt_q),
    .w_i         (w),
    .ctl_i       (ctl),
    .out_valid_o (out_valid_o),
    .integral_o  (integral_o),
    .saturated_o (saturated_o)
  );

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result word");

  a_sat_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |=> saturated_o)
    else $error("saturated flag cleared");
`endif

endmodule

`default_nettype wire
